// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the allocator RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never hold out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed");

// a implies b in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// a implies b in the following cycle
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ===== rtl/gfba_pkg.sv =====
// Shared types and constants of the grouped free-block allocator.
// No dependencies.
`default_nettype none

package gfba_pkg;

  localparam int GROUP_SIZE_DEF = 100;
  localparam int MAX_GROUPS_DEF = 64;
  localparam int BLOCK_BITS_DEF = 24;

  localparam int IN_BITS  = 24;
  localparam int OUT_BITS = 24;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_SPACE   = 2'd1;
  localparam logic [1:0] ST_SPILL_FULL = 2'd2;

  typedef struct packed {
    logic [OUT_BITS-1:0] block;
    logic [1:0]          status;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/grouped_free_block_allocator.sv =====
// Top level of the grouped free-block allocator.
// Depends on gfba_pkg, gfba_store, gfba_ctrl and gfba_out.
//
//   channel | ports                                    | direction
//   in_     | in_valid in_stall in_operation            | item in
//           | in_block_number                          |
//   out_    | out_valid out_stall out_granted_block      | result out
//           | out_status                               |
//
// A free is done in S_IDLE; a nonzero-count allocate goes on to S_READ: the
// store read is registered and the count update waits for the popped value.
// Reset clears the fill count and group base; the store itself is not cleared.
// A result waits in the output register plus one skid entry; the input
// stalls only while an allocate read is in flight or the skid entry is full.
`default_nettype none

module grouped_free_block_allocator #(
  parameter int GROUP_SIZE = gfba_pkg::GROUP_SIZE_DEF,
  parameter int MAX_GROUPS = gfba_pkg::MAX_GROUPS_DEF,
  parameter int BLOCK_BITS = gfba_pkg::BLOCK_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_operation,
  input  wire logic [gfba_pkg::IN_BITS-1:0] in_block_number,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [gfba_pkg::OUT_BITS-1:0]     out_granted_block,
  output logic [1:0]                        out_status
);

  import gfba_pkg::*;

  localparam int DEPTH  = GROUP_SIZE * MAX_GROUPS;
  localparam int ADDR_W = $clog2(DEPTH);

  logic                  room;
  logic                  push;
  res_t                  push_res;
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic [BLOCK_BITS-1:0] wr_data;
  logic                  rd_en;
  logic [ADDR_W-1:0]     rd_addr;
  logic [BLOCK_BITS-1:0] rd_data;

  gfba_store #(
    .DEPTH  (DEPTH),
    .WIDTH  (BLOCK_BITS),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  gfba_ctrl #(
    .GROUP_SIZE (GROUP_SIZE),
    .MAX_GROUPS (MAX_GROUPS),
    .BLOCK_BITS (BLOCK_BITS),
    .ADDR_W     (ADDR_W)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_block_number (in_block_number),
    .room            (room),
    .push            (push),
    .push_res        (push_res),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .rd_en           (rd_en),
    .rd_addr         (rd_addr),
    .rd_data         (rd_data)
  );

  gfba_out u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .push_res          (push_res),
    .room              (room),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_granted_block (out_granted_block),
    .out_status        (out_status)
  );

endmodule

`default_nettype wire

// ===== rtl/gfba_store.sv =====
// Group store: one-write, one-read synchronous memory, registered read data.
// No dependencies.
`default_nettype none

module gfba_store #(
  parameter int DEPTH  = 6400,
  parameter int WIDTH  = 24,
  parameter int ADDR_W = 13
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gfba_out.sv =====
// Result register with one skid entry for the out_ channel.
// Depends on gfba_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module gfba_out (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire gfba_pkg::res_t        push_res,
  output logic                       room,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [gfba_pkg::OUT_BITS-1:0] out_granted_block,
  output logic [1:0]                 out_status
);

  import gfba_pkg::*;

  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  res_t out_r, out_nxt;
  res_t skid_r, skid_nxt;
  logic out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign room     = !skid_valid_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else if (push) begin
        out_nxt       = push_res;
        out_valid_nxt = 1'b1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (push) begin
      skid_nxt       = push_res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_granted_block = out_r.block;
  assign out_status        = out_r.status;

  `ASSERT_NEVER(a_no_push_when_full, clk, rst_n, push && skid_valid_r)
  `ASSERT_IMPLIES(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r)
  `ASSERT_NEXT(a_skid_drains, clk, rst_n, skid_valid_r && out_free, out_valid_r && !skid_valid_r)

endmodule

`default_nettype wire

// ===== rtl/gfba_ctrl.sv =====
// Sequencer: keeps top group base and fill count, drives the group store.
// Depends on gfba_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module gfba_ctrl #(
  parameter int GROUP_SIZE = gfba_pkg::GROUP_SIZE_DEF,
  parameter int MAX_GROUPS = gfba_pkg::MAX_GROUPS_DEF,
  parameter int BLOCK_BITS = gfba_pkg::BLOCK_BITS_DEF,
  parameter int ADDR_W     = 13
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       in_operation,
  input  wire logic [gfba_pkg::IN_BITS-1:0] in_block_number,
  input  wire logic                       room,
  output logic                            push,
  output gfba_pkg::res_t                  push_res,
  output logic                            wr_en,
  output logic [ADDR_W-1:0]               wr_addr,
  output logic [BLOCK_BITS-1:0]           wr_data,
  output logic                            rd_en,
  output logic [ADDR_W-1:0]               rd_addr,
  input  wire logic [BLOCK_BITS-1:0]      rd_data
);

  import gfba_pkg::*;

  localparam int CNT_W = $clog2(GROUP_SIZE + 1);
  localparam logic [ADDR_W-1:0] GS_A      = ADDR_W'(GROUP_SIZE);
  localparam logic [ADDR_W-1:0] LAST_BASE = ADDR_W'((MAX_GROUPS - 1) * GROUP_SIZE);
  localparam logic [CNT_W-1:0]  GS_C      = CNT_W'(GROUP_SIZE);

  typedef enum logic {S_IDLE, S_READ} state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic              force_r, force_nxt;
  logic [CNT_W-1:0]  cnt_dec;
  logic [BLOCK_BITS-1:0] got;
  logic              accept;

  assign in_stall = (state_r == S_READ) || !room;
  assign accept   = in_valid && !in_stall;
  assign cnt_dec  = cnt_r - 1'b1;
  assign wr_data  = BLOCK_BITS'(32'(in_block_number));
  assign got      = force_r ? '0 : rd_data;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    base_nxt  = base_r;
    force_nxt = force_r;
    wr_en     = 1'b0;
    wr_addr   = base_r + ADDR_W'(cnt_r);
    rd_en     = 1'b0;
    rd_addr   = base_r + ADDR_W'(cnt_dec);
    push      = 1'b0;
    push_res  = '{block: '0, status: ST_OK};
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_operation == OP_ALLOC) begin
            if (cnt_r == '0) begin
              push            = 1'b1;
              push_res.status = ST_NO_SPACE;
            end else begin
              rd_en     = 1'b1;
              cnt_nxt   = cnt_dec;
              // entry 0 of group 0 is never written; its read is forced to zero, the end marker
              force_nxt = (base_r == '0) && (cnt_r == CNT_W'(1));
              state_nxt = S_READ;
            end
          end else begin
            push = 1'b1;
            if (cnt_r == '0) begin
              wr_en    = 1'b1;
              wr_addr  = ADDR_W'(1);
              base_nxt = '0;
              cnt_nxt  = CNT_W'(2);
            end else if (cnt_r >= GS_C) begin
              if (base_r == LAST_BASE) begin
                push_res.status = ST_SPILL_FULL;
              end else begin
                wr_en    = 1'b1;
                wr_addr  = base_r + GS_A;
                base_nxt = base_r + GS_A;
                cnt_nxt  = CNT_W'(1);
              end
            end else begin
              wr_en   = 1'b1;
              cnt_nxt = cnt_r + 1'b1;
            end
          end
        end
      end
      S_READ: begin
        push      = 1'b1;
        state_nxt = S_IDLE;
        if (got == '0) begin
          cnt_nxt         = '0;
          base_nxt        = '0;
          push_res.status = ST_NO_SPACE;
        end else begin
          push_res.block = OUT_BITS'(32'(got));
          if (cnt_r == '0) begin
            base_nxt = base_r - GS_A;
            cnt_nxt  = GS_C;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      base_r  <= '0;
      force_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      base_r  <= base_nxt;
      force_r <= force_nxt;
    end
  end

  `ASSERT_NEVER(a_cnt_bound, clk, rst_n, cnt_r > GS_C)
  `ASSERT_NEVER(a_base_bound, clk, rst_n, base_r > LAST_BASE)
  `ASSERT_NEXT(a_read_done, clk, rst_n, state_r == S_READ, state_r == S_IDLE)
  `ASSERT_NEVER(a_write_read, clk, rst_n, wr_en && rd_en)

endmodule

`default_nettype wire
